// ===== hdl/ctcv_pkg.sv =====
// ----------------------------------------------------------------------------
// ctcv_pkg
// shared constants, codes and the byte-wide crc-32 update for the chunked
// transfer verifier
// ----------------------------------------------------------------------------
package ctcv_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int MAX_WRITE_DEF   = 256;

    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

    localparam logic [7:0] OP_BEGIN = 8'd1;
    localparam logic [7:0] OP_DATA  = 8'd2;
    localparam logic [7:0] OP_END   = 8'd3;

    localparam int BEGIN_BYTES = 7;
    localparam int HDR_BYTES   = 6;

    typedef enum logic [2:0] {
        ST_RECEIVING   = 3'd0,
        ST_CHUNK_OK    = 3'd1,
        ST_BAD_LENGTH  = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_CHECK_FAIL  = 3'd4,
        ST_VERIFIED    = 3'd5
    } status_t;

    // reflected crc-32, one byte folded in: eight shift/xor steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== hdl/chunked_transfer_crc_verifier.sv =====
// ----------------------------------------------------------------------------
// chunked_transfer_crc_verifier
// checks begin / data / end command writes of a chunked transfer against
// the announced length and reflected crc-32
// ----------------------------------------------------------------------------
// One byte of a command write is taken per cycle, back to back, while
// item_stall is low. Each byte is captured in an input register, and a
// single pass of logic (including the eight-step byte-wide crc-32 update)
// then updates the transfer state and, on the last byte of a write, loads
// the result register. The result register lets the next byte in while a
// result waits to be taken; the input stalls only when a byte that ends a
// write finds the result register still full and stalled. A byte with no
// open write and no first mark is dropped.
module chunked_transfer_crc_verifier
#(
    parameter int MAX_PAYLOAD = ctcv_pkg::MAX_PAYLOAD_DEF,
    parameter int MAX_WRITE   = ctcv_pkg::MAX_WRITE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_of_write,
    input  logic        last_of_write,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [10:0] payload_length
);

    import ctcv_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int WC_W  = $clog2(MAX_WRITE + 2);
    localparam int SUM_W = ((LEN_W > WC_W) ? LEN_W : WC_W) + 1;

    // input stage
    logic       stg_full_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_first_reg;
    logic       stg_last_reg;

    // transfer state
    logic [LEN_W-1:0] expected_length_reg, expected_length_next;
    logic [LEN_W-1:0] committed_length_reg, committed_length_next;
    logic [31:0]      target_crc_reg, target_crc_next;
    logic [31:0]      committed_crc_reg, committed_crc_next;
    logic [31:0]      tentative_crc_reg, tentative_crc_next;
    logic [WC_W-1:0]  write_byte_count_reg, write_byte_count_next;
    logic [7:0]       current_opcode_reg, current_opcode_next;
    logic [47:0]      header_bytes_reg, header_bytes_next;

    // result register
    logic             result_valid_reg;
    status_t          status_reg, status_next;
    logic [LEN_W-1:0] plen_reg;

    logic            produces;
    logic            advance;
    logic [WC_W-1:0] count;
    logic [WC_W-1:0] n_bytes;
    logic [2:0]      hdr_idx;
    logic [15:0]     begin_len;
    logic [SUM_W-1:0] len_sum;
    logic [LEN_W+10:0] plen_ext;

    assign produces   = stg_last_reg && (stg_first_reg || (write_byte_count_reg != '0));
    assign advance    = stg_full_reg && (!produces || !result_valid_reg || !result_stall);
    assign item_stall = stg_full_reg && !advance;

    always_comb
    begin
        current_opcode_next   = current_opcode_reg;
        header_bytes_next     = header_bytes_reg;
        tentative_crc_next    = tentative_crc_reg;
        write_byte_count_next = write_byte_count_reg;
        expected_length_next  = expected_length_reg;
        committed_length_next = committed_length_reg;
        committed_crc_next    = committed_crc_reg;
        target_crc_next       = target_crc_reg;
        status_next           = ST_UNSUPPORTED;
        hdr_idx               = 3'(write_byte_count_reg - 1'b1);

        if (stg_first_reg)
        begin
            current_opcode_next   = stg_byte_reg;
            header_bytes_next     = '0;
            tentative_crc_next    = committed_crc_reg;
            write_byte_count_next = WC_W'(1);
        end
        else if (write_byte_count_reg != '0)
        begin
            if (write_byte_count_reg <= WC_W'(HDR_BYTES))
            begin
                header_bytes_next[8*hdr_idx +: 8] = stg_byte_reg;
            end
            if (current_opcode_reg == OP_DATA)
            begin
                tentative_crc_next = crc_byte(tentative_crc_reg, stg_byte_reg);
            end
            if (write_byte_count_reg <= WC_W'(MAX_WRITE))
            begin
                write_byte_count_next = write_byte_count_reg + 1'b1;
            end
        end

        count     = write_byte_count_next;
        n_bytes   = count - 1'b1;
        begin_len = header_bytes_next[15:0];
        len_sum   = SUM_W'(committed_length_reg) + SUM_W'(n_bytes);

        if (produces)
        begin
            write_byte_count_next = '0;
            if (count > WC_W'(MAX_WRITE))
            begin
                status_next = ST_BAD_LENGTH;
            end
            else if (current_opcode_next == OP_BEGIN)
            begin
                if (count != WC_W'(BEGIN_BYTES) || begin_len == 16'd0 ||
                    {1'b0, begin_len} > 17'(MAX_PAYLOAD))
                begin
                    status_next = ST_BAD_LENGTH;
                end
                else
                begin
                    expected_length_next  = LEN_W'(begin_len);
                    committed_length_next = '0;
                    committed_crc_next    = CRC_INIT;
                    target_crc_next       = header_bytes_next[47:16];
                    status_next           = ST_RECEIVING;
                end
            end
            else if (current_opcode_next == OP_DATA)
            begin
                if (expected_length_reg == '0 ||
                    len_sum > SUM_W'(expected_length_reg))
                begin
                    status_next = ST_BAD_LENGTH;
                end
                else
                begin
                    committed_length_next = LEN_W'(len_sum);
                    committed_crc_next    = tentative_crc_next;
                    status_next           = ST_CHUNK_OK;
                end
            end
            else if (current_opcode_next == OP_END)
            begin
                if (count != WC_W'(1) || committed_length_reg != expected_length_reg ||
                    ~committed_crc_reg != target_crc_reg)
                begin
                    status_next = ST_CHECK_FAIL;
                end
                else
                begin
                    status_next = ST_VERIFIED;
                end
                expected_length_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_full_reg         <= 1'b0;
            result_valid_reg     <= 1'b0;
            expected_length_reg  <= '0;
            committed_length_reg <= '0;
            target_crc_reg       <= '0;
            committed_crc_reg    <= CRC_INIT;
            tentative_crc_reg    <= CRC_INIT;
            write_byte_count_reg <= '0;
            current_opcode_reg   <= '0;
            header_bytes_reg     <= '0;
        end
        else
        begin
            if (!item_stall)
            begin
                stg_full_reg <= item_valid;
            end
            if (advance)
            begin
                expected_length_reg  <= expected_length_next;
                committed_length_reg <= committed_length_next;
                target_crc_reg       <= target_crc_next;
                committed_crc_reg    <= committed_crc_next;
                tentative_crc_reg    <= tentative_crc_next;
                write_byte_count_reg <= write_byte_count_next;
                current_opcode_reg   <= current_opcode_next;
                header_bytes_reg     <= header_bytes_next;
            end
            if (advance && produces)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            stg_byte_reg  <= data_byte;
            stg_first_reg <= first_of_write;
            stg_last_reg  <= last_of_write;
        end
        if (advance && produces)
        begin
            status_reg <= status_next;
            plen_reg   <= committed_length_next;
        end
    end

    assign plen_ext       = {11'd0, plen_reg};
    assign result_valid   = result_valid_reg;
    assign status         = status_reg;
    assign payload_length = plen_ext[10:0];

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chunked transfer crc verifier
// ----------------------------------------------------------------------------
// A fixed opening sequence covers stale end after reset, stray bytes, unknown
// opcodes, rejected data, bad begin, empty data and a clean transfer. Random
// transfers with occasional corruption, overruns, restarts and oversized
// writes follow. Every accepted byte runs through a local model of the
// verifier; results are checked in order against it or a hand-written row.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ctcv_pkg::*;

    localparam int PAYLOAD_MAX = MAX_PAYLOAD_DEF;
    localparam int WRITE_MAX   = MAX_WRITE_DEF;
    localparam int ITEM_TARGET = 900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int PRESSURE_AT = 450;
    localparam int TAIL_ITEMS  = 120;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        logic [7:0]  b;
        bit          is_first;
        bit          is_last;
        bit          typed;
        status_t     st;
        logic [10:0] len;
    } stim_t;

    typedef struct {
        status_t     st;
        logic [10:0] len;
    } verdict_t;

    typedef logic [7:0] byte_list_t[$];

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        item_valid     = 1'b0;
    logic        item_stall;
    logic [7:0]  data_byte      = 8'h00;
    logic        first_of_write = 1'b0;
    logic        last_of_write  = 1'b0;
    logic        result_valid;
    logic        result_stall   = 1'b0;
    logic [2:0]  status;
    logic [10:0] payload_length;

    // hand-written expectation riding along with the item on the wire
    bit          row_typed = 1'b0;
    status_t     row_st    = ST_RECEIVING;
    logic [10:0] row_len   = '0;

    stim_t    stim_q[$];
    verdict_t expected_verdicts[$];
    int       strays        = 0;
    int       oversize_left = 3;
    int       items_taken   = 0;
    int       mismatches    = 0;

    // local copy of the verifier state
    logic [10:0] xfer_len       = '0;
    logic [10:0] kept_len       = '0;
    logic [31:0] goal_crc       = '0;
    logic [31:0] kept_crc       = CRC_INIT;
    logic [31:0] run_crc        = CRC_INIT;
    logic [8:0]  bytes_in_write = '0;
    logic [7:0]  write_op       = '0;
    logic [47:0] hdr            = '0;

    chunked_transfer_crc_verifier dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .data_byte      (data_byte),
        .first_of_write (first_of_write),
        .last_of_write  (last_of_write),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .payload_length (payload_length)
    );

    always #6 clk = ~clk;

    // bit-serial form of the reflected crc-32 byte update
    function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ b[k])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic bit calm_phase(input int pos);
        return (pos >= 200 && pos < 300) || (pos + TAIL_ITEMS >= stim_q.size());
    endfunction

    task automatic predict_write_byte(input logic [7:0] b, input bit is_first, input bit is_last,
                                      output bit has_result, output verdict_t v);
        int          pos;
        int unsigned cnt;
        int unsigned n;
        has_result = 1'b0;
        v.st       = ST_RECEIVING;
        v.len      = '0;
        if (is_first)
        begin
            write_op       = b;
            hdr            = '0;
            run_crc        = kept_crc;
            bytes_in_write = 9'd1;
        end
        else if (bytes_in_write == 0)
        begin
            return;
        end
        else
        begin
            pos = int'(bytes_in_write);
            if (pos <= HDR_BYTES)
                hdr[(pos - 1) * 8 +: 8] = b;
            if (write_op == OP_DATA)
                run_crc = crc32_fold(run_crc, b);
            if (pos <= WRITE_MAX)
                bytes_in_write = bytes_in_write + 9'd1;
        end
        if (!is_last)
            return;

        cnt            = 32'(bytes_in_write);
        bytes_in_write = '0;
        has_result     = 1'b1;
        if (cnt > WRITE_MAX)
        begin
            v.st = ST_BAD_LENGTH;
        end
        else if (write_op == OP_BEGIN)
        begin
            if (cnt != BEGIN_BYTES || hdr[15:0] == 0 || hdr[15:0] > PAYLOAD_MAX)
            begin
                v.st = ST_BAD_LENGTH;
            end
            else
            begin
                xfer_len = hdr[10:0];
                kept_len = '0;
                kept_crc = CRC_INIT;
                goal_crc = hdr[47:16];
                v.st     = ST_RECEIVING;
            end
        end
        else if (write_op == OP_DATA)
        begin
            n = cnt - 1;
            if (xfer_len == 0 || kept_len + n > xfer_len)
            begin
                v.st = ST_BAD_LENGTH;
            end
            else
            begin
                kept_len = kept_len + n[10:0];
                kept_crc = run_crc;
                v.st     = ST_CHUNK_OK;
            end
        end
        else if (write_op == OP_END)
        begin
            if (cnt != 1 || kept_len != xfer_len || ~kept_crc != goal_crc)
                v.st = ST_CHECK_FAIL;
            else
                v.st = ST_VERIFIED;
            xfer_len = '0;
        end
        else
        begin
            v.st = ST_UNSUPPORTED;
        end
        v.len = kept_len;
    endtask

    task automatic add_item(input logic [7:0] b, input bit is_first, input bit is_last);
        stim_t s;
        s.b        = b;
        s.is_first = is_first;
        s.is_last  = is_last;
        s.typed    = 1'b0;
        s.st       = ST_RECEIVING;
        s.len      = '0;
        stim_q.push_back(s);
    endtask

    task automatic add_write(input byte_list_t w, input bit close);
        for (int i = 0; i < w.size(); i++)
            add_item(w[i], i == 0, close && i == w.size() - 1);
    endtask

    task automatic add_typed_write(input byte_list_t w, input status_t st, input logic [10:0] len);
        stim_t s;
        add_write(w, 1'b1);
        s       = stim_q.pop_back();
        s.typed = 1'b1;
        s.st    = st;
        s.len   = len;
        stim_q.push_back(s);
    endtask

    // stray bytes only land where no write is open
    task automatic add_stray();
        if (stim_q.size() != 0 && stim_q[stim_q.size() - 1].is_last)
        begin
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            strays++;
        end
    endtask

    task automatic add_transfer();
        byte_list_t  payload;
        byte_list_t  w;
        logic [31:0] crc;
        logic [15:0] announced;
        int          total;
        int          sent;
        int          stop_at;
        int          chunk;
        int          span;
        int          pick;
        int          flip;
        total = ($urandom_range(0, 24) == 0) ? $urandom_range(PAYLOAD_MAX - 3, PAYLOAD_MAX)
                                             : $urandom_range(1, 40);
        crc = CRC_INIT;
        payload = {};
        for (int k = 0; k < total; k++)
        begin
            payload.push_back(8'($urandom_range(0, 255)));
            crc = crc32_fold(crc, payload[k]);
        end
        crc = ~crc;
        if ($urandom_range(0, 7) == 0)
        begin
            flip = $urandom_range(0, 31);
            crc[flip] = ~crc[flip];
        end
        announced = 16'(total);
        w = {OP_BEGIN, announced[7:0], announced[15:8], crc[7:0], crc[15:8], crc[23:16],
             crc[31:24]};
        if ($urandom_range(0, 11) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                void'(w.pop_back());
            else
                w.push_back(8'($urandom_range(0, 255)));
        end
        add_write(w, 1'b1);

        // large transfers only send part of the payload before the end
        stop_at = (total > 64) ? $urandom_range(1, WRITE_MAX - 1) : total;
        if ($urandom_range(0, 14) == 0)
            stop_at = $urandom_range(0, stop_at - 1);
        sent = 0;
        while (sent < stop_at)
        begin
            pick = $urandom_range(0, 19);
            w = {OP_DATA};
            if (pick == 0)
            begin
                add_write(w, 1'b1);
            end
            else if (pick == 1)
            begin
                chunk = total - sent + $urandom_range(1, 3);
                if (chunk < WRITE_MAX)
                begin
                    for (int k = 0; k < chunk; k++)
                        w.push_back(8'($urandom_range(0, 255)));
                    add_write(w, 1'b1);
                end
            end
            else if (pick == 2)
            begin
                // write abandoned by the next first mark
                for (int k = $urandom_range(0, 4); k > 0; k--)
                    w.push_back(8'($urandom_range(0, 255)));
                add_write(w, 1'b0);
            end
            else
            begin
                span = ($urandom_range(0, 9) == 0) ? WRITE_MAX - 1 : 16;
                chunk = $urandom_range(1, (stop_at - sent < span) ? stop_at - sent : span);
                for (int k = 0; k < chunk; k++)
                    w.push_back(payload[sent + k]);
                sent += chunk;
                add_write(w, 1'b1);
            end
            if ($urandom_range(0, 29) == 0)
                add_stray();
        end

        w = {OP_END};
        if ($urandom_range(0, 14) == 0)
            w.push_back(8'($urandom_range(0, 255)));
        add_write(w, 1'b1);
    endtask

    task automatic add_noise();
        byte_list_t  w;
        logic [15:0] bad_len;
        int          kind;
        kind = $urandom_range(0, 9);
        w = {};
        case (kind)
            0, 1, 2, 3:
            begin
                for (int k = $urandom_range(1, 8); k > 0; k--)
                    w.push_back(8'($urandom_range(0, 255)));
                add_write(w, 1'b1);
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       bad_len = 16'd0;
                    1:       bad_len = 16'(PAYLOAD_MAX + 1);
                    2:       bad_len = 16'hffff;
                    default: bad_len = 16'($urandom_range(0, 16'hffff));
                endcase
                w = {OP_BEGIN, bad_len[7:0], bad_len[15:8]};
                for (int k = 0; k < 4; k++)
                    w.push_back(8'($urandom_range(0, 255)));
                add_write(w, 1'b1);
            end
            5:
            begin
                w = {OP_END};
                for (int k = $urandom_range(1, 3); k > 0; k--)
                    w.push_back(8'($urandom_range(0, 255)));
                add_write(w, 1'b1);
            end
            6:
            begin
                w = {OP_DATA};
                for (int k = $urandom_range(0, 5); k > 0; k--)
                    w.push_back(8'($urandom_range(0, 255)));
                add_write(w, 1'b1);
            end
            7:
            begin
                for (int k = $urandom_range(1, 5); k > 0; k--)
                    w.push_back(8'($urandom_range(0, 255)));
                add_write(w, 1'b0);
            end
            8:
            begin
                for (int k = $urandom_range(1, 3); k > 0; k--)
                    add_stray();
            end
            default:
            begin
                if (oversize_left > 0)
                begin
                    oversize_left--;
                    w.push_back(8'($urandom_range(OP_BEGIN, OP_END)));
                    for (int k = $urandom_range(WRITE_MAX, WRITE_MAX + 3); k > 0; k--)
                        w.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    w.push_back(8'($urandom_range(0, 255)));
                end
                add_write(w, 1'b1);
            end
        endcase
    endtask

    task automatic build_stimulus();
        logic [31:0] c;
        // an end right after reset checks the empty payload and verifies
        add_typed_write({OP_END}, ST_VERIFIED, 11'd0);
        add_item(8'hff, 1'b0, 1'b1);
        strays++;
        add_typed_write({8'h00}, ST_UNSUPPORTED, 11'd0);
        add_typed_write({8'hff}, ST_UNSUPPORTED, 11'd0);
        add_typed_write({OP_DATA}, ST_BAD_LENGTH, 11'd0);
        add_typed_write({OP_BEGIN, 8'h00, 8'h00, 8'haa, 8'h55, 8'hff, 8'h00}, ST_BAD_LENGTH,
                        11'd0);
        c = ~crc32_fold(crc32_fold(CRC_INIT, 8'h00), 8'hff);
        add_typed_write({OP_BEGIN, 8'h02, 8'h00, c[7:0], c[15:8], c[23:16], c[31:24]},
                        ST_RECEIVING, 11'd0);
        add_typed_write({OP_DATA}, ST_CHUNK_OK, 11'd0);
        add_typed_write({OP_DATA, 8'h00, 8'hff}, ST_CHUNK_OK, 11'd2);
        add_typed_write({OP_END}, ST_VERIFIED, 11'd2);

        while (stim_q.size() - strays < ITEM_TARGET)
        begin
            if ($urandom_range(0, 6) == 0)
                add_noise();
            else
                add_transfer();
        end
    endtask

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        bit       has;
        verdict_t v;
        verdict_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result status %0d length %0d",
                                            status, payload_length));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (status !== want.st)
                        flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
                    if (payload_length !== want.len)
                        flag_mismatch($sformatf("payload_length %0d, want %0d",
                                                payload_length, want.len));
                end
            end
            if (item_valid && !item_stall)
            begin
                items_taken++;
                predict_write_byte(data_byte, first_of_write, last_of_write, has, v);
                if (has)
                begin
                    if (row_typed)
                    begin
                        v.st  = row_st;
                        v.len = row_len;
                    end
                    expected_verdicts.push_back(v);
                end
            end
        end
    end

    initial
    begin : feed
        stim_t s;
        build_stimulus();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int idx = 0; idx < stim_q.size(); idx++)
        begin
            s = stim_q[idx];
            if (!calm_phase(idx) && $urandom_range(0, 11) == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            item_valid     <= 1'b1;
            data_byte      <= s.b;
            first_of_write <= s.is_first;
            last_of_write  <= s.is_last;
            row_typed      <= s.typed;
            row_st         <= s.st;
            row_len        <= s.len;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
        end
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("[chunked_transfer_crc_verifier] OK");
        else
            $display("[chunked_transfer_crc_verifier] ERROR");
        $finish;
    end

    initial
    begin : drain
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && items_taken >= PRESSURE_AT)
            begin
                // long hold-off so the result register fills and the input backs up
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!calm_phase(items_taken) && $urandom_range(0, 9) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        for (int cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("[chunked_transfer_crc_verifier] ERROR");
        $finish;
    end

endmodule
